// ===== design/stepper_ramp_pulse_generator_defines.svh =====
// Assertion macros shared by the stepper ramp pulse generator.
`ifndef STEPPER_RAMP_PULSE_GENERATOR_DEFINES_SVH
`define STEPPER_RAMP_PULSE_GENERATOR_DEFINES_SVH

// Check cons in the same cycle as ante.
`define SRPG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante.
`define SRPG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/srpg_pkg.sv =====
// Shared types and codes of the stepper ramp pulse generator.
`timescale 1ns / 1ps
package srpg_pkg;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [1:0] REG_USE_STEP_TOGGLE = 2'd0;
  localparam logic [1:0] REG_MOVE_PULSES     = 2'd1;
  localparam logic [1:0] REG_MAX_RUN_TIME_MS = 2'd2;
  localparam logic [1:0] REG_MOVE_DIRECTION  = 2'd3;

  localparam logic [2:0] MODE_TICK        = 3'd0;
  localparam logic [2:0] MODE_START       = 3'd1;
  localparam logic [2:0] MODE_STOP        = 3'd2;
  localparam logic [2:0] MODE_FORCED_STOP = 3'd3;
  localparam logic [2:0] MODE_TABLE_WRITE = 3'd4;

  localparam logic [1:0] PH_STOPPED = 2'd0;
  localparam logic [1:0] PH_ACCEL   = 2'd1;
  localparam logic [1:0] PH_RUN     = 2'd2;
  localparam logic [1:0] PH_DECEL   = 2'd3;

  localparam logic [1:0] MS_STOPPED  = 2'd0;
  localparam logic [1:0] MS_MOVING   = 2'd1;
  localparam logic [1:0] MS_STOPPING = 2'd2;

  typedef struct packed {
    logic        step_toggle_en;
    logic [31:0] move_pulses;
    logic [31:0] max_run_time_ms;
    logic        move_direction;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [5:0]  table_index;
    logic [23:0] table_value;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic       step_pulse;
    logic       step_level;
    logic       motor_enable;
    logic       direction_out;
    logic [1:0] motion_state;
    logic       movement_done;
    logic       cmd_ok;
  } result_t;

endpackage

// ===== design/srpg_stream_if.sv =====
// Valid/ready request channel carrying one payload.
`timescale 1ns / 1ps
interface srpg_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/srpg_cfg_regs.sv =====
// APB configuration registers of the stepper ramp pulse generator.
`timescale 1ns / 1ps
module srpg_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [srpg_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [srpg_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [srpg_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output srpg_pkg::cfg_t                      cfg_o
);

  srpg_pkg::cfg_t cfg_q;
  logic [1:0]     reg_idx;
  logic           wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        srpg_pkg::REG_USE_STEP_TOGGLE: cfg_q.step_toggle_en  <= pwdata[0];
        srpg_pkg::REG_MOVE_PULSES:     cfg_q.move_pulses     <= pwdata;
        srpg_pkg::REG_MAX_RUN_TIME_MS: cfg_q.max_run_time_ms <= pwdata;
        srpg_pkg::REG_MOVE_DIRECTION:  cfg_q.move_direction  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      srpg_pkg::REG_USE_STEP_TOGGLE: prdata = {31'd0, cfg_q.step_toggle_en};
      srpg_pkg::REG_MOVE_PULSES:     prdata = cfg_q.move_pulses;
      srpg_pkg::REG_MAX_RUN_TIME_MS: prdata = cfg_q.max_run_time_ms;
      srpg_pkg::REG_MOVE_DIRECTION:  prdata = {31'd0, cfg_q.move_direction};
      default:                       prdata = '0;
    endcase
  end

endmodule

// ===== design/srpg_ramp_table.sv =====
// Ramp interval memory: one write port, two registered read ports.
`timescale 1ns / 1ps
module srpg_ramp_table #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned WIDTH  = 24,
  parameter int unsigned ADDR_W = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output logic [WIDTH-1:0]  rdata_a_o,
  output logic [WIDTH-1:0]  rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Forward a write to a read of the same entry.
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_a_i)) begin
      rdata_a_q <= wdata_i;
    end else begin
      rdata_a_q <= mem_q[raddr_a_i];
    end
    if (we_i && (waddr_i == raddr_b_i)) begin
      rdata_b_q <= wdata_i;
    end else begin
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

endmodule

// ===== design/srpg_ramp_core.sv =====
// Ramp state machine, step counters and command handling.
`timescale 1ns / 1ps
module srpg_ramp_core #(
  parameter int unsigned TABLE_DEPTH   = 64,
  parameter int unsigned TICK_US       = 10,
  parameter int unsigned INTERVAL_BITS = 24,
  parameter int unsigned POS_W         = 6
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_en_i,
  input  srpg_pkg::item_t          item_i,
  input  srpg_pkg::cfg_t           cfg_i,
  input  logic [INTERVAL_BITS-1:0] rd_up_i,
  input  logic [INTERVAL_BITS-1:0] rd_dn_i,
  output logic [POS_W-1:0]         raddr_up_o,
  output logic [POS_W-1:0]         raddr_dn_o,
  output logic                     tbl_we_o,
  output logic [POS_W-1:0]         tbl_waddr_o,
  output logic [INTERVAL_BITS-1:0] tbl_wdata_o,
  output srpg_pkg::result_t        res_o
);

  localparam int unsigned SUM_W = INTERVAL_BITS + 11;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(TABLE_DEPTH - 1);
  localparam logic [INTERVAL_BITS-1:0] IV_MAX = {INTERVAL_BITS{1'b1}};

  logic [1:0]               phase_q, phase_d;
  logic                     pend_q, pend_d;
  logic [POS_W-1:0]         pos_q, pos_d;
  logic [INTERVAL_BITS-1:0] acc_q, acc_d;
  logic [INTERVAL_BITS-1:0] iv_q, iv_d;
  logic [31:0]              pulses_q, pulses_d;
  logic [31:0]              thr_q, thr_d;
  logic [31:0]              start_q, start_d;
  logic                     step_q, step_d;
  logic                     en_q, en_d;
  logic                     dir_q, dir_d;

  logic [SUM_W-1:0]         acc_sum;
  logic [INTERVAL_BITS-1:0] acc_sat;
  logic [31:0]              elapsed_ms;
  logic                     is_idle;
  logic                     is_moving;
  logic                     end_mv;
  logic [1:0]               adv_phase;
  logic [POS_W-1:0]         adv_pos;
  logic [INTERVAL_BITS-1:0] adv_iv;
  logic [31:0]              idx_ext;
  logic [55:0]              val_ext;

  always_comb begin
    phase_d     = phase_q;
    pend_d      = pend_q;
    pos_d       = pos_q;
    acc_d       = acc_q;
    iv_d        = iv_q;
    pulses_d    = pulses_q;
    thr_d       = thr_q;
    start_d     = start_q;
    step_d      = step_q;
    en_d        = en_q;
    dir_d       = dir_q;
    res_o       = '0;
    tbl_we_o    = 1'b0;
    end_mv      = 1'b0;
    adv_phase   = phase_q;
    adv_pos     = pos_q;
    adv_iv      = iv_q;
    idx_ext     = 32'(item_i.table_index);
    val_ext     = 56'(item_i.table_value);
    tbl_waddr_o = idx_ext[POS_W-1:0];
    tbl_wdata_o = val_ext[INTERVAL_BITS-1:0];
    acc_sum     = SUM_W'(acc_q) + SUM_W'(TICK_US);
    acc_sat     = (acc_sum > SUM_W'(IV_MAX)) ? IV_MAX : acc_sum[INTERVAL_BITS-1:0];
    elapsed_ms  = item_i.now_ms - start_q;
    is_idle     = (phase_q == srpg_pkg::PH_STOPPED) && !pend_q;
    is_moving   = (phase_q != srpg_pkg::PH_STOPPED) && !pend_q;

    if (step_en_i) begin
      case (item_i.mode)
        srpg_pkg::MODE_TICK: begin
          if (phase_q != srpg_pkg::PH_STOPPED) begin
            acc_d = acc_sat;
            if (acc_sat >= iv_q) begin
              acc_d = '0;
              case (phase_q)
                srpg_pkg::PH_ACCEL: begin
                  adv_iv = rd_up_i;
                  if (pos_q == LAST_POS) begin
                    adv_phase = srpg_pkg::PH_RUN;
                  end else begin
                    adv_pos = pos_q + POS_W'(1);
                  end
                end
                srpg_pkg::PH_RUN: begin
                  if ((cfg_i.move_pulses != 32'd0) && (pulses_q >= thr_q)) begin
                    adv_phase = srpg_pkg::PH_DECEL;
                  end
                end
                srpg_pkg::PH_DECEL: begin
                  if (pos_q > POS_W'(1)) begin
                    adv_pos = pos_q - POS_W'(1);
                    adv_iv  = rd_dn_i;
                  end else begin
                    adv_phase = srpg_pkg::PH_STOPPED;
                  end
                end
                default: ;
              endcase
              if ((cfg_i.max_run_time_ms != 32'd0) && (elapsed_ms >= cfg_i.max_run_time_ms)) begin
                adv_phase = srpg_pkg::PH_STOPPED;
              end
              if ((cfg_i.move_pulses != 32'd0) && (pulses_q >= cfg_i.move_pulses)) begin
                adv_phase = srpg_pkg::PH_STOPPED;
              end
              if (adv_phase != srpg_pkg::PH_STOPPED) begin
                phase_d          = adv_phase;
                pos_d            = adv_pos;
                iv_d             = adv_iv;
                pulses_d         = pulses_q + 32'd1;
                res_o.step_pulse = 1'b1;
                if (cfg_i.step_toggle_en) begin
                  step_d = ~step_q;
                end
              end else begin
                end_mv              = 1'b1;
                res_o.movement_done = 1'b1;
              end
            end
          end
        end
        srpg_pkg::MODE_START: begin
          if (is_idle) begin
            thr_d        = cfg_i.move_pulses - (cfg_i.move_pulses >> 1);
            en_d         = 1'b1;
            dir_d        = cfg_i.move_direction;
            iv_d         = rd_dn_i;
            pos_d        = '0;
            pulses_d     = '0;
            acc_d        = '0;
            start_d      = item_i.now_ms;
            pend_d       = 1'b0;
            phase_d      = srpg_pkg::PH_ACCEL;
            res_o.cmd_ok = 1'b1;
          end
        end
        srpg_pkg::MODE_STOP: begin
          if (is_moving) begin
            pend_d       = 1'b1;
            phase_d      = srpg_pkg::PH_DECEL;
            res_o.cmd_ok = 1'b1;
          end
        end
        srpg_pkg::MODE_FORCED_STOP: begin
          if (is_moving) begin
            end_mv              = 1'b1;
            res_o.movement_done = 1'b1;
            res_o.cmd_ok        = 1'b1;
          end
        end
        srpg_pkg::MODE_TABLE_WRITE: begin
          if (is_idle && (idx_ext < 32'(TABLE_DEPTH))) begin
            tbl_we_o     = 1'b1;
            res_o.cmd_ok = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (end_mv) begin
      phase_d  = srpg_pkg::PH_STOPPED;
      pend_d   = 1'b0;
      pos_d    = '0;
      acc_d    = '0;
      iv_d     = '0;
      pulses_d = '0;
      thr_d    = '0;
      start_d  = '0;
      en_d     = 1'b0;
      if (cfg_i.step_toggle_en) begin
        step_d = 1'b0;
      end
    end

    res_o.step_level    = step_d;
    res_o.motor_enable  = en_d;
    res_o.direction_out = dir_d;
    if (pend_d) begin
      res_o.motion_state = srpg_pkg::MS_STOPPING;
    end else if (phase_d != srpg_pkg::PH_STOPPED) begin
      res_o.motion_state = srpg_pkg::MS_MOVING;
    end else begin
      res_o.motion_state = srpg_pkg::MS_STOPPED;
    end

    raddr_up_o = (pos_d == LAST_POS) ? pos_d : pos_d + POS_W'(1);
    raddr_dn_o = (pos_d == '0) ? '0 : pos_d - POS_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= srpg_pkg::PH_STOPPED;
      pend_q   <= 1'b0;
      pos_q    <= '0;
      acc_q    <= '0;
      iv_q     <= '0;
      pulses_q <= '0;
      thr_q    <= '0;
      start_q  <= '0;
      step_q   <= 1'b0;
      en_q     <= 1'b0;
      dir_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      pend_q   <= pend_d;
      pos_q    <= pos_d;
      acc_q    <= acc_d;
      iv_q     <= iv_d;
      pulses_q <= pulses_d;
      thr_q    <= thr_d;
      start_q  <= start_d;
      step_q   <= step_d;
      en_q     <= en_d;
      dir_q    <= dir_d;
    end
  end

endmodule

// ===== design/stepper_ramp_pulse_generator.sv =====
// Top level of the stepper ramp pulse generator.
//
//   channel   direction  payload                              handshake
//   in_i      in         mode, table_index, table_value, now  valid/ready
//   out_o     out        step, enable, direction, state flags valid/ready
//   apb       in/out     step_toggle_en .. move_direction     psel/penable
//
// One request per cycle unless out_o stalls: a request is held in the input register;
// its result is computed in one pass and is then valid in the result register.
// Registered neighbor reads of the table hold the entries next to the ramp position.
// Reset clears control state; the ramp table holds no reset value.
// While a result waits, one more request is taken into the input register, then
// in_i.ready drops until the result is taken; nothing is dropped.
`timescale 1ns / 1ps
`include "stepper_ramp_pulse_generator_defines.svh"
module stepper_ramp_pulse_generator #(
  parameter int unsigned TABLE_DEPTH   = 64,
  parameter int unsigned TICK_US       = 10,
  parameter int unsigned INTERVAL_BITS = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  srpg_stream_if.sink                     in_i,
  srpg_stream_if.source                   out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [srpg_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [srpg_pkg::APB_DATA_W-1:0] pwdata,
  output logic [srpg_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int unsigned POS_W = $clog2(TABLE_DEPTH);

  srpg_pkg::cfg_t    cfg;
  srpg_pkg::item_t   in_q;
  srpg_pkg::result_t res;
  srpg_pkg::result_t out_q;
  logic              in_valid_q;
  logic              out_valid_q;
  logic              advance;
  logic              in_ready;

  logic [POS_W-1:0]         raddr_up;
  logic [POS_W-1:0]         raddr_dn;
  logic [INTERVAL_BITS-1:0] rd_up;
  logic [INTERVAL_BITS-1:0] rd_dn;
  logic                     tbl_we;
  logic [POS_W-1:0]         tbl_waddr;
  logic [INTERVAL_BITS-1:0] tbl_wdata;

  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready    = !in_valid_q || advance;
  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  srpg_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  srpg_ramp_table #(
    .DEPTH  (TABLE_DEPTH),
    .WIDTH  (INTERVAL_BITS),
    .ADDR_W (POS_W)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (tbl_we),
    .waddr_i   (tbl_waddr),
    .wdata_i   (tbl_wdata),
    .raddr_a_i (raddr_up),
    .raddr_b_i (raddr_dn),
    .rdata_a_o (rd_up),
    .rdata_b_o (rd_dn)
  );

  srpg_ramp_core #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .TICK_US       (TICK_US),
    .INTERVAL_BITS (INTERVAL_BITS),
    .POS_W         (POS_W)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_en_i   (advance),
    .item_i      (in_q),
    .cfg_i       (cfg),
    .rd_up_i     (rd_up),
    .rd_dn_i     (rd_dn),
    .raddr_up_o  (raddr_up),
    .raddr_dn_o  (raddr_dn),
    .tbl_we_o    (tbl_we),
    .tbl_waddr_o (tbl_waddr),
    .tbl_wdata_o (tbl_wdata),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_ready) begin
      in_q <= in_i.data;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  `SRPG_ASSERT_NEXT(a_accept_loads, in_i.valid && in_ready, in_valid_q, "accepted request lost")
  `SRPG_ASSERT_NEXT(a_tick_no_ok, advance && (in_q.mode == srpg_pkg::MODE_TICK),
                    !out_q.cmd_ok, "tick reported as command")
  `SRPG_ASSERT_SAME(a_pulse_enabled, out_valid_q && out_q.step_pulse,
                    out_q.motor_enable && (out_q.motion_state != srpg_pkg::MS_STOPPED),
                    "step pulse while driver disabled")

endmodule
